// ===== rtl/core/volume_central_difference_gradient_assert.svh =====
// assertion macros for the gradient block checker
// expects clk and rst_n in the scope where a macro is used
`ifndef VOLUME_CENTRAL_DIFFERENCE_GRADIENT_ASSERT_SVH
`define VOLUME_CENTRAL_DIFFERENCE_GRADIENT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define VCDG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vcdg property violated");

// next-cycle implication, disabled during reset
`define VCDG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vcdg property violated");

`endif

// ===== rtl/core/vcdg_pkg.sv =====
// shared types, widths and codes for the volume gradient block
// no dependencies
`default_nettype none

package vcdg_pkg;

    // default largest volume edge
    localparam int unsigned MAX_DIM_DEF = 256;

    // field widths
    localparam int unsigned CFG_W     = 9;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned GRAD_W    = 17;
    localparam int unsigned SLOT_W    = 2;

    // size register reset value
    localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;

    // last slot of the three-plane ring
    localparam logic [SLOT_W-1:0] SLOT_LAST = 2'd2;

    // most negative 17-bit code, never produced by a difference of two samples
    localparam logic [GRAD_W-1:0] GRAD_NEG_LIMIT = 17'h10000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2
    } cfg_reg_t;

    // request function codes
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_DRAIN  = 1'b1;

    // control to datapath bundle, one per accepted request
    typedef struct packed {
        logic                emit;     // gradient leaves for this request
        logic                prime;    // first voxel of the volume, loads center
        logic                drain;    // emission from a drain request
        logic                x_first;
        logic                y_first;
        logic                y_last;
        logic                z_first;
        logic                z_last;
        logic                last;     // final voxel of the volume
        logic                fwd;      // next voxel is the one written this cycle
        logic [SAMPLE_W-1:0] sample;
    } dp_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/vcdg_ifs.sv =====
// valid/ready channel interfaces for voxel input, gradient output and config
// depends on vcdg_pkg
`default_nettype none

// voxel request channel
interface vcdg_vox_if import vcdg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                func;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output func, output sample, input ready);
    modport sink   (input valid, input func, input sample, output ready);
endinterface

// gradient result channel
interface vcdg_grad_if import vcdg_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic signed [GRAD_W-1:0] grad_z;
    logic                     last_voxel;

    modport source (output valid, output grad_x, output grad_y, output grad_z,
                    output last_voxel, input ready);
    modport sink   (input valid, input grad_x, input grad_y, input grad_z,
                    input last_voxel, output ready);
endinterface

// configuration write channel
interface vcdg_cfg_if import vcdg_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/vcdg_ring_mem.sv =====
// three-plane voxel ring store, one write port and two registered read ports
// no package dependencies
`default_nettype none

module vcdg_ring_mem #(
    parameter int unsigned W     = 16,
    parameter int unsigned AW    = 18,
    parameter int unsigned DEPTH = 196608
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [W-1:0]  wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr_a,
    input  wire logic [AW-1:0] raddr_b,
    output logic      [W-1:0]  rdata_a,
    output logic      [W-1:0]  rdata_b
);

    logic [W-1:0] mem_array [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    // read ports, old data on a same-cycle write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem_array[raddr_a];
            rdata_b <= mem_array[raddr_b];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/vcdg_ctrl.sv =====
// size registers, write and emit coordinate counters, ring addressing
// depends on vcdg_pkg
`default_nettype none

module vcdg_ctrl import vcdg_pkg::*; #(
    parameter  int unsigned MAX_DIM = MAX_DIM_DEF,
    localparam int unsigned DW      = $clog2(MAX_DIM),
    localparam int unsigned SW      = DW + 1,
    localparam int unsigned AW      = SLOT_W + 2 * DW
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 vox_accept,
    input  wire logic                 vox_func,
    input  wire logic [SAMPLE_W-1:0]  vox_sample,
    output logic                      mem_we,
    output logic      [AW-1:0]        mem_waddr,
    output logic                      mem_re,
    output logic      [AW-1:0]        raddr_next,
    output logic      [AW-1:0]        raddr_yn,
    output logic      [AW-1:0]        raddr_yp,
    output logic      [AW-1:0]        raddr_xp,
    output dp_req_t                   req
);

    function automatic logic [SW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [SW-1:0] d;
        if (v == '0)
            d = SW'(1);
        else if (32'(v) > MAX_DIM)
            d = SW'(MAX_DIM);
        else
            d = SW'(v);
        return d;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_LAST) ? '0 : s + SLOT_W'(1);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
        return (s == '0) ? SLOT_LAST : s - SLOT_W'(1);
    endfunction

    logic [CFG_W-1:0]  size_x_reg, size_x_next;
    logic [CFG_W-1:0]  size_y_reg, size_y_next;
    logic [CFG_W-1:0]  size_z_reg, size_z_next;
    logic [DW-1:0]     wi_reg, wi_next, wj_reg, wj_next, wk_reg, wk_next;
    logic [SLOT_W-1:0] ws_reg, ws_next;
    logic              wr_done_reg, wr_done_next;
    logic [DW-1:0]     ei_reg, ei_next, ej_reg, ej_next, ek_reg, ek_next;
    logic [SLOT_W-1:0] es_reg, es_next;
    logic              em_done_reg, em_done_next;

    logic [DW-1:0]     lx, ly, lz;
    logic              cfg_hit;
    logic              sample_acc, emit_smp, emit_drn, emit;
    logic              wr_last, em_last;
    logic [DW-1:0]     wi_adv, wj_adv, wk_adv, ei_adv, ej_adv, ek_adv;
    logic [SLOT_W-1:0] ws_adv, es_adv;

    // last index along each axis from the clamped sizes
    always_comb
    begin
        lx = DW'(clamp_dim(size_x_reg) - SW'(1));
        ly = DW'(clamp_dim(size_y_reg) - SW'(1));
        lz = DW'(clamp_dim(size_z_reg) - SW'(1));
    end

    // raster advance of the write and emit coordinates
    always_comb
    begin
        wi_adv = wi_reg;
        wj_adv = wj_reg;
        wk_adv = wk_reg + DW'(1);
        ws_adv = ws_reg;
        if (wk_reg == lz)
        begin
            wk_adv = '0;
            wj_adv = wj_reg + DW'(1);
            if (wj_reg == ly)
            begin
                wj_adv = '0;
                wi_adv = wi_reg + DW'(1);
                ws_adv = slot_inc(ws_reg);
            end
        end
        ei_adv = ei_reg;
        ej_adv = ej_reg;
        ek_adv = ek_reg + DW'(1);
        es_adv = es_reg;
        if (ek_reg == lz)
        begin
            ek_adv = '0;
            ej_adv = ej_reg + DW'(1);
            if (ej_reg == ly)
            begin
                ej_adv = '0;
                ei_adv = ei_reg + DW'(1);
                es_adv = slot_inc(es_reg);
            end
        end
        wr_last = (wi_reg == lx) && (wj_reg == ly) && (wk_reg == lz);
        em_last = (ei_reg == lx) && (ej_reg == ly) && (ek_reg == lz);
    end

    // request decode
    always_comb
    begin
        cfg_hit    = cfg_valid && ((cfg_index == REG_SIZE_X) || (cfg_index == REG_SIZE_Y)
                                   || (cfg_index == REG_SIZE_Z));
        sample_acc = vox_accept && (vox_func == FUNC_SAMPLE) && !wr_done_reg;
        emit_smp   = sample_acc && (wi_reg != '0) && !em_done_reg;
        emit_drn   = vox_accept && (vox_func == FUNC_DRAIN) && wr_done_reg && !em_done_reg;
        emit       = emit_smp || emit_drn;
    end

    // ring addresses: slot, row, column
    always_comb
    begin
        mem_we     = sample_acc;
        mem_waddr  = {ws_reg, wj_reg, wk_reg};
        mem_re     = emit;
        raddr_next = {es_adv, ej_adv, ek_adv};
        raddr_yn   = {es_reg, ej_reg + DW'(1), ek_reg};
        raddr_yp   = {es_reg, ej_reg - DW'(1), ek_reg};
        raddr_xp   = {slot_dec(es_reg), ej_reg, ek_reg};
    end

    // bundle for the datapath
    always_comb
    begin
        req.emit    = emit;
        req.prime   = sample_acc && (wi_reg == '0) && (wj_reg == '0) && (wk_reg == '0);
        req.drain   = emit_drn;
        req.x_first = (ei_reg == '0);
        req.y_first = (ej_reg == '0);
        req.y_last  = (ej_reg == ly);
        req.z_first = (ek_reg == '0);
        req.z_last  = (ek_reg == lz);
        req.last    = em_last;
        req.fwd     = sample_acc && (mem_waddr == raddr_next);
        req.sample  = vox_sample;
    end

    // next state of registers and counters
    always_comb
    begin
        size_x_next  = size_x_reg;
        size_y_next  = size_y_reg;
        size_z_next  = size_z_reg;
        wi_next      = wi_reg;
        wj_next      = wj_reg;
        wk_next      = wk_reg;
        ws_next      = ws_reg;
        wr_done_next = wr_done_reg;
        ei_next      = ei_reg;
        ej_next      = ej_reg;
        ek_next      = ek_reg;
        es_next      = es_reg;
        em_done_next = em_done_reg;
        if (cfg_hit)
        begin
            case (cfg_index)
                REG_SIZE_X: size_x_next = cfg_data;
                REG_SIZE_Y: size_y_next = cfg_data;
                REG_SIZE_Z: size_z_next = cfg_data;
                default:    size_x_next = size_x_reg;
            endcase
            wi_next      = '0;
            wj_next      = '0;
            wk_next      = '0;
            ws_next      = '0;
            wr_done_next = 1'b0;
            ei_next      = '0;
            ej_next      = '0;
            ek_next      = '0;
            es_next      = '0;
            em_done_next = 1'b0;
        end
        else
        begin
            if (sample_acc)
            begin
                if (wr_last)
                begin
                    wr_done_next = 1'b1;
                end
                else
                begin
                    wi_next = wi_adv;
                    wj_next = wj_adv;
                    wk_next = wk_adv;
                    ws_next = ws_adv;
                end
            end
            if (emit)
            begin
                if (em_last)
                begin
                    em_done_next = 1'b1;
                end
                else
                begin
                    ei_next = ei_adv;
                    ej_next = ej_adv;
                    ek_next = ek_adv;
                    es_next = es_adv;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg  <= SIZE_RESET;
            size_y_reg  <= SIZE_RESET;
            size_z_reg  <= SIZE_RESET;
            wi_reg      <= '0;
            wj_reg      <= '0;
            wk_reg      <= '0;
            ws_reg      <= '0;
            wr_done_reg <= 1'b0;
            ei_reg      <= '0;
            ej_reg      <= '0;
            ek_reg      <= '0;
            es_reg      <= '0;
            em_done_reg <= 1'b0;
        end
        else
        begin
            size_x_reg  <= size_x_next;
            size_y_reg  <= size_y_next;
            size_z_reg  <= size_z_next;
            wi_reg      <= wi_next;
            wj_reg      <= wj_next;
            wk_reg      <= wk_next;
            ws_reg      <= ws_next;
            wr_done_reg <= wr_done_next;
            ei_reg      <= ei_next;
            ej_reg      <= ej_next;
            ek_reg      <= ek_next;
            es_reg      <= es_next;
            em_done_reg <= em_done_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/vcdg_grad.sv =====
// gradient datapath: read stage, neighbor select, differences, output register
// depends on vcdg_pkg
`default_nettype none

module vcdg_grad import vcdg_pkg::*; (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dp_req_t             req,
    input  wire logic [SAMPLE_W-1:0] rd_next,
    input  wire logic [SAMPLE_W-1:0] rd_yn,
    input  wire logic [SAMPLE_W-1:0] rd_yp,
    input  wire logic [SAMPLE_W-1:0] rd_xp,
    input  wire logic                out_ready,
    output logic                     busy,
    output logic                     out_valid,
    output logic signed [GRAD_W-1:0] grad_x,
    output logic signed [GRAD_W-1:0] grad_y,
    output logic signed [GRAD_W-1:0] grad_z,
    output logic                     last_voxel
);

    function automatic logic [GRAD_W-1:0] diff(input logic [SAMPLE_W-1:0] hi,
                                               input logic [SAMPLE_W-1:0] lo);
        return {1'b0, hi} - {1'b0, lo};
    endfunction

    logic                s1_valid_reg, s1_valid_next;
    dp_req_t             s1_reg, s1_next;
    logic [SAMPLE_W-1:0] cur_reg, cur_next;
    logic [SAMPLE_W-1:0] prev_reg, prev_next;
    logic                out_valid_reg, out_valid_next;
    logic [GRAD_W-1:0]   gx_reg, gx_next, gy_reg, gy_next, gz_reg, gz_next;
    logic                last_reg, last_next;

    logic                take, advance;
    logic [SAMPLE_W-1:0] next_val, xn, xp, yn, yp, zn, zp;

    // output slot free or leaving this cycle
    always_comb
    begin
        take    = !out_valid_reg || out_ready;
        advance = s1_valid_reg && take;
        busy    = s1_valid_reg && !take;
    end

    // neighbor select with edge clamping to the center voxel
    always_comb
    begin
        next_val = s1_reg.fwd ? s1_reg.sample : rd_next;
        xn = s1_reg.drain   ? cur_reg : s1_reg.sample;
        xp = s1_reg.x_first ? cur_reg : rd_xp;
        yn = s1_reg.y_last  ? cur_reg : rd_yn;
        yp = s1_reg.y_first ? cur_reg : rd_yp;
        zn = s1_reg.z_last  ? cur_reg : next_val;
        zp = s1_reg.z_first ? cur_reg : prev_reg;
    end

    // pipeline next state
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_next        = s1_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        out_valid_next = out_valid_reg;
        gx_next        = gx_reg;
        gy_next        = gy_reg;
        gz_next        = gz_reg;
        last_next      = last_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            s1_valid_next  = 1'b0;
            out_valid_next = 1'b1;
            gx_next        = diff(xn, xp);
            gy_next        = diff(yn, yp);
            gz_next        = diff(zn, zp);
            last_next      = s1_reg.last;
            cur_next       = next_val;
            prev_next      = cur_reg;
        end
        if (req.emit)
        begin
            s1_valid_next = 1'b1;
            s1_next       = req;
        end
        // first voxel of a volume seeds the center window
        if (req.prime)
        begin
            cur_next = req.sample;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_reg   <= s1_next;
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
        gx_reg   <= gx_next;
        gy_reg   <= gy_next;
        gz_reg   <= gz_next;
        last_reg <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign grad_x     = signed'(gx_reg);
    assign grad_y     = signed'(gy_reg);
    assign grad_z     = signed'(gz_reg);
    assign last_voxel = last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/volume_central_difference_gradient.sv =====
// top level of the streamed 3-d central difference gradient
// depends on vcdg_pkg, vcdg_ifs, vcdg_ring_mem, vcdg_ctrl, vcdg_grad
//
//  channel  role    payload                                  handshake
//  vox      sink    func, sample                             valid / ready
//  grad     source  grad_x, grad_y, grad_z, last_voxel       valid / ready
//  cfg      sink    index, data (size_x, size_y, size_z)     valid / ready
//
// one request per clock while vox.ready is high; the gradient for a request leaves
// through one read stage of the ring store and one output register.
// the ring is two copies of a three-plane store, each with one write and two read
// ports, giving the four neighbor reads per gradient in the same cycle.
// vox.ready drops only while a result waits in the output register and another
// sits in the read stage; cfg is always ready.
// reset clears counters and presets sizes at once; the ring needs no clearing pass.
`default_nettype none

module volume_central_difference_gradient import vcdg_pkg::*; #(
    parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    vcdg_vox_if.sink     vox,
    vcdg_grad_if.source  grad,
    vcdg_cfg_if.sink     cfg
);

    localparam int unsigned DW    = $clog2(MAX_DIM);
    localparam int unsigned AW    = SLOT_W + 2 * DW;
    localparam int unsigned DEPTH = 3 * (1 << (2 * DW));

    logic                mem_we, mem_re, busy;
    logic [AW-1:0]       mem_waddr, raddr_next, raddr_yn, raddr_yp, raddr_xp;
    logic [SAMPLE_W-1:0] rd_next, rd_yn, rd_yp, rd_xp;
    dp_req_t             req;

    // handshakes
    assign vox.ready = !busy;
    assign cfg.ready = 1'b1;

    // counters and addressing
    vcdg_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .vox_accept (vox.valid && vox.ready),
        .vox_func   (vox.func),
        .vox_sample (vox.sample),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_re     (mem_re),
        .raddr_next (raddr_next),
        .raddr_yn   (raddr_yn),
        .raddr_yp   (raddr_yp),
        .raddr_xp   (raddr_xp),
        .req        (req)
    );

    // ring copy serving the next voxel and next row
    vcdg_ring_mem #(
        .W     (SAMPLE_W),
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_ring_fwd (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (vox.sample),
        .re      (mem_re),
        .raddr_a (raddr_next),
        .raddr_b (raddr_yn),
        .rdata_a (rd_next),
        .rdata_b (rd_yn)
    );

    // ring copy serving the previous row and previous plane
    vcdg_ring_mem #(
        .W     (SAMPLE_W),
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_ring_back (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (vox.sample),
        .re      (mem_re),
        .raddr_a (raddr_yp),
        .raddr_b (raddr_xp),
        .rdata_a (rd_yp),
        .rdata_b (rd_xp)
    );

    // differences and output register
    vcdg_grad u_grad (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rd_next    (rd_next),
        .rd_yn      (rd_yn),
        .rd_yp      (rd_yp),
        .rd_xp      (rd_xp),
        .out_ready  (grad.ready),
        .busy       (busy),
        .out_valid  (grad.valid),
        .grad_x     (grad.grad_x),
        .grad_y     (grad.grad_y),
        .grad_z     (grad.grad_z),
        .last_voxel (grad.last_voxel)
    );

endmodule

`default_nettype wire

// ===== rtl/core/vcdg_checker.sv =====
// port-level checker for the gradient block, bound to the top level
// depends on vcdg_pkg and volume_central_difference_gradient_assert.svh
`default_nettype none

`include "volume_central_difference_gradient_assert.svh"

module vcdg_checker import vcdg_pkg::*; (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 vox_ready,
    input wire logic                 cfg_valid,
    input wire logic                 cfg_ready,
    input wire logic [CFG_IDX_W-1:0] cfg_index,
    input wire logic                 grad_valid,
    input wire logic                 grad_ready,
    input wire logic [GRAD_W-1:0]    grad_x,
    input wire logic [GRAD_W-1:0]    grad_y,
    input wire logic [GRAD_W-1:0]    grad_z,
    input wire logic                 grad_last
);

    logic done_reg, done_next;
    logic new_volume;

    // volume finished once its final gradient is taken, until a size write
    always_comb
    begin
        new_volume = cfg_valid && cfg_ready
                     && ((cfg_index == REG_SIZE_X) || (cfg_index == REG_SIZE_Y)
                         || (cfg_index == REG_SIZE_Z));
        done_next = done_reg;
        if (grad_valid && grad_ready && grad_last)
            done_next = 1'b1;
        if (new_volume)
            done_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    // stalled result holds
    `VCDG_ASSERT_NEXT(a_grad_hold, grad_valid && !grad_ready, grad_valid && $stable(grad_x) && $stable(grad_y) && $stable(grad_z) && $stable(grad_last))

    // input never blocked while the output register is empty
    `VCDG_ASSERT_IMPL(a_ready_when_empty, !grad_valid, vox_ready)

    // nothing follows the final gradient of a volume
    `VCDG_ASSERT_IMPL(a_quiet_after_last, done_reg, !grad_valid)

    // difference of two unsigned samples stays above the most negative code
    `VCDG_ASSERT_IMPL(a_grad_range, grad_valid, (grad_x != GRAD_NEG_LIMIT) && (grad_y != GRAD_NEG_LIMIT) && (grad_z != GRAD_NEG_LIMIT))

endmodule

bind volume_central_difference_gradient vcdg_checker u_vcdg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .vox_ready  (vox.ready),
    .cfg_valid  (cfg.valid),
    .cfg_ready  (cfg.ready),
    .cfg_index  (cfg.index),
    .grad_valid (grad.valid),
    .grad_ready (grad.ready),
    .grad_x     (grad.grad_x),
    .grad_y     (grad.grad_y),
    .grad_z     (grad.grad_z),
    .grad_last  (grad.last_voxel)
);

`default_nettype wire
